/* rtl/cst_pkg.sv */
package cst_pkg;

   localparam int NumSemsDefault   = 32;
   localparam int QueueDepthDefault = 8;
   localparam int PidBitsDefault   = 6;
   localparam int CountBitsDefault = 16;

   typedef enum logic [1:0] {
      CMD_CREATE = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_WAIT   = 2'd2,
      CMD_SIGNAL = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_ID   = 3'd1,
      ST_WAITERS  = 3'd2,
      ST_NO_SLOT  = 3'd3,
      ST_Q_FULL   = 3'd4,
      ST_OVERFLOW = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [4:0]  sem_index;
      logic [15:0] initial_count;
      logic [5:0]  caller_pid;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] allocated_index;
      logic       caller_blocked;
      logic       wake_valid;
      logic [5:0] woken_pid;
   } rsp_type;

   typedef enum logic [1:0] {
      EX_IDLE  = 2'd0,
      EX_READ  = 2'd1,
      EX_EXEC  = 2'd2,
      EX_OUT   = 2'd3
   } exec_state_type;

endpackage

/* rtl/cst_front.sv */
module cst_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cst_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_ready,
   output cst_pkg::req_type q_data
);
   import cst_pkg::*;

   // Two-entry queue decouples the request port from the executor.
   req_type    buf_ff [2];
   req_type    buf_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_data    = buf_ff[0];

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         buf_in[0] = buf_ff[1];
         cnt_in    = cnt_in - 2'd1;
      end
      if (push) begin
         buf_in[cnt_in[0]] = req_data;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
endmodule

/* rtl/cst_back.sv */
module cst_back #(
   parameter int NUM_SEMS    = cst_pkg::NumSemsDefault,
   parameter int QUEUE_DEPTH = cst_pkg::QueueDepthDefault,
   parameter int PID_BITS    = cst_pkg::PidBitsDefault,
   parameter int COUNT_BITS  = cst_pkg::CountBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  cst_pkg::req_type q_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cst_pkg::rsp_type rsp_data
);
   import cst_pkg::*;

   localparam int IdxW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int PosW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int TotW = $clog2(QUEUE_DEPTH + 1);
   localparam int MemW = IdxW + PosW;
   localparam int PidDepth = NUM_SEMS * (2 ** PosW);

   logic [NUM_SEMS-1:0] in_use_ff, in_use_in;
   logic [PosW-1:0]     head_ff [NUM_SEMS];
   logic [PosW-1:0]     tail_ff [NUM_SEMS];
   logic [TotW-1:0]     total_ff [NUM_SEMS];
   logic [COUNT_BITS-1:0] count_mem [NUM_SEMS];
   logic [PID_BITS-1:0]   pid_mem [PidDepth];

   exec_state_type state_ff, state_in;
   req_type        cur_ff;
   logic [IdxW-1:0] slot_ff, slot_in;
   logic            found_ff, found_in;
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [PID_BITS-1:0]   pid_rd_ff;
   rsp_type         rsp_ff, rsp_in;

   logic [IdxW-1:0] idx;
   logic            idx_ok;
   logic [PosW-1:0] hd, tl;
   logic [TotW-1:0] tot;
   logic [COUNT_BITS-1:0] init_v;
   logic            cnt_we, pid_we, ptr_we;
   logic [COUNT_BITS-1:0] cnt_wd;
   logic [PosW-1:0] hd_wd, tl_wd;
   logic [TotW-1:0] tot_wd;

   assign idx    = IdxW'(cur_ff.sem_index);
   assign idx_ok = ({27'd0, cur_ff.sem_index} < 32'(NUM_SEMS)) && in_use_ff[idx];
   assign hd     = head_ff[idx];
   assign tl     = tail_ff[idx];
   assign tot    = total_ff[idx];
   assign init_v = COUNT_BITS'(cur_ff.initial_count);

   function automatic logic [PosW-1:0] nxt(input logic [PosW-1:0] p);
      return (32'(p) + 1 >= QUEUE_DEPTH) ? '0 : PosW'(32'(p) + 1);
   endfunction

   // Lowest free slot, computed combinationally during READ.
   always_comb begin
      slot_in  = slot_ff;
      found_in = found_ff;
      if (state_ff == EX_READ) begin
         found_in = 1'b0;
         slot_in  = '0;
         for (int i = NUM_SEMS - 1; i >= 0; i--) begin
            if (!in_use_ff[i]) begin
               found_in = 1'b1;
               slot_in  = IdxW'(i);
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EX_IDLE: if (q_valid)   state_in = EX_READ;
         EX_READ:                state_in = EX_EXEC;
         EX_EXEC:                state_in = EX_OUT;
         EX_OUT:  if (rsp_ready) state_in = EX_IDLE;
         default:                state_in = EX_IDLE;
      endcase
   end

   assign q_ready   = (state_ff == EX_IDLE);
   assign rsp_valid = (state_ff == EX_OUT);
   assign rsp_data  = rsp_ff;

   // Execute: decide result and table updates.
   always_comb begin
      rsp_in    = rsp_ff;
      in_use_in = in_use_ff;
      cnt_we = 1'b0; pid_we = 1'b0; ptr_we = 1'b0;
      cnt_wd = cnt_rd_ff;
      hd_wd = hd; tl_wd = tl; tot_wd = tot;
      if (state_ff == EX_EXEC) begin
         rsp_in = '0;
         rsp_in.status = ST_OK;
         case (cmd_type'(cur_ff.command))
            CMD_CREATE: begin
               if (!found_ff) begin
                  rsp_in.status = ST_NO_SLOT;
               end else begin
                  in_use_in[slot_ff] = 1'b1;
                  rsp_in.allocated_index = 5'(slot_ff);
               end
            end
            CMD_FREE: begin
               if (!idx_ok) rsp_in.status = ST_BAD_ID;
               else if (tot != '0) rsp_in.status = ST_WAITERS;
               else in_use_in[idx] = 1'b0;
            end
            CMD_WAIT: begin
               if (!idx_ok) begin
                  rsp_in.status = ST_BAD_ID;
               end else if (cnt_rd_ff != '0) begin
                  cnt_we = 1'b1;
                  cnt_wd = cnt_rd_ff - 1'b1;
               end else if (32'(tot) >= QUEUE_DEPTH) begin
                  rsp_in.status = ST_Q_FULL;
               end else begin
                  pid_we = 1'b1; ptr_we = 1'b1;
                  tl_wd  = nxt(tl);
                  tot_wd = tot + 1'b1;
                  rsp_in.caller_blocked = 1'b1;
               end
            end
            CMD_SIGNAL: begin
               if (!idx_ok) begin
                  rsp_in.status = ST_BAD_ID;
               end else if (tot != '0) begin
                  ptr_we = 1'b1;
                  hd_wd  = nxt(hd);
                  tot_wd = tot - 1'b1;
                  rsp_in.wake_valid = 1'b1;
                  rsp_in.woken_pid  = 6'(pid_rd_ff);
               end else if (&cnt_rd_ff) begin
                  rsp_in.status = ST_OVERFLOW;
               end else begin
                  cnt_we = 1'b1;
                  cnt_wd = cnt_rd_ff + 1'b1;
               end
            end
            default: rsp_in.status = ST_BAD_ID;
         endcase
      end
   end

   // Memories: read in READ, written in EXEC.
   always_ff @(posedge clock) begin
      if (state_ff == EX_READ) begin
         cnt_rd_ff <= count_mem[idx];
         pid_rd_ff <= pid_mem[MemW'({idx, hd})];
      end
      if (state_ff == EX_EXEC && cur_ff.command == CMD_CREATE && found_ff) begin
         count_mem[slot_ff] <= init_v;
      end else if (cnt_we) begin
         count_mem[idx] <= cnt_wd;
      end
      if (pid_we) begin
         pid_mem[MemW'({idx, tl})] <= PID_BITS'(cur_ff.caller_pid);
      end
   end

   always_ff @(posedge clock) begin
      if (q_valid && q_ready) cur_ff <= q_data;
      rsp_ff   <= rsp_in;
      slot_ff  <= slot_in;
      found_ff <= found_in;
      if (reset) begin
         state_ff  <= EX_IDLE;
         in_use_ff <= '0;
         for (int i = 0; i < NUM_SEMS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            total_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         in_use_ff <= in_use_in;
         if (state_ff == EX_EXEC && cur_ff.command == CMD_CREATE && found_ff) begin
            head_ff[slot_ff]  <= '0;
            tail_ff[slot_ff]  <= '0;
            total_ff[slot_ff] <= '0;
         end else if (ptr_we) begin
            head_ff[idx]  <= hd_wd;
            tail_ff[idx]  <= tl_wd;
            total_ff[idx] <= tot_wd;
         end
      end
   end
endmodule

/* rtl/counting_semaphore_table.sv */
// Counting semaphore table with per-slot FIFO of waiting process ids.
// A request passes the front queue and the executor's read and execute states; the response is then registered.
// The executor takes no new request until the response is taken (idle, read, execute, out sequence).
// Reset (synchronous, active high) frees every slot and empties every wait queue;
// count and waiter memories are not cleared, since each entry is written before use.
module counting_semaphore_table #(
   parameter int NUM_SEMS    = cst_pkg::NumSemsDefault,
   parameter int QUEUE_DEPTH = cst_pkg::QueueDepthDefault,
   parameter int PID_BITS    = cst_pkg::PidBitsDefault,
   parameter int COUNT_BITS  = cst_pkg::CountBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cst_pkg::rsp_type rsp_data
);
   import cst_pkg::*;

   // The front queue holds up to two requests so the sender is not stalled
   // while the back end works through a request.
   logic    q_valid, q_ready;
   req_type q_data;

   cst_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .q_valid, .q_ready, .q_data
   );

   // The back end reads the slot tables, applies the command and holds the
   // response in a register until it is taken.
   cst_back #(
      .NUM_SEMS(NUM_SEMS), .QUEUE_DEPTH(QUEUE_DEPTH),
      .PID_BITS(PID_BITS), .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule
